FILE: src/mlta_pkg.sv
// ----------------------------------------------------------------------------
// mlta_pkg
// Shared types and constants of the MAC learning table with aging.
// ----------------------------------------------------------------------------
package mlta_pkg;

	localparam int MAC_W   = 48;
	localparam int PORT_W  = 4;
	localparam int STAMP_W = 16;
	localparam int TMO_W   = 15;
	localparam int CNT_W   = 7;
	localparam int REQ_W   = 2;

	localparam logic [CNT_W-1:0] CNT_MAX     = 7'd127;
	localparam logic [TMO_W-1:0] TMO_DEFAULT = 15'd30;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LEARN  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

	// one stored table entry
	typedef struct packed {
		logic               valid;
		logic [MAC_W-1:0]   mac;
		logic [PORT_W-1:0]  port;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// per-entry verdict from the evaluator
	typedef struct packed {
		logic hit;     // valid and MAC matches
		logic free;    // slot not in use
		logic expire;  // valid and older than the timeout
	} eval_t;

endpackage

FILE: src/mlta_mem.sv
// ----------------------------------------------------------------------------
// mlta_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlta_mem #(
	parameter int ENTRIES = 64
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(ENTRIES)-1:0]    waddr,
	input  mlta_pkg::entry_t              wdata,
	input  logic                          re,
	input  logic [$clog2(ENTRIES)-1:0]    raddr,
	output mlta_pkg::entry_t              rdata
);

	mlta_pkg::entry_t mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/mlta_eval.sv
// ----------------------------------------------------------------------------
// mlta_eval
// Judges one entry read from the store: match, free slot, aged out.
// ----------------------------------------------------------------------------
module mlta_eval (
	input  mlta_pkg::entry_t                  entry,
	input  logic [mlta_pkg::MAC_W-1:0]        mac,
	input  logic [mlta_pkg::STAMP_W-1:0]      now,
	input  logic [mlta_pkg::TMO_W-1:0]        timeout,
	output mlta_pkg::eval_t                   ev
);

	logic [mlta_pkg::STAMP_W-1:0] age;

	// modular age
	assign age       = now - entry.stamp;
	assign ev.hit    = entry.valid && (entry.mac == mac);
	assign ev.free   = !entry.valid;
	assign ev.expire = entry.valid && (age > {1'b0, timeout});

endmodule

FILE: src/mac_learning_table_aging_core.sv
// ----------------------------------------------------------------------------
// mac_learning_table_aging_core
// MAC-to-port learning table with lookup, learn and timed aging.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready): one beat per request, req_type selects
//     lookup, learn or one-second tick; mac_addr and port_in ride along.
//   out channel (out_valid/out_ready): one result beat per request.
//   cfg channel (cfg_valid/cfg_ready): writes age_timeout; always ready,
//     write it only while no request is in flight.
// Timing: every lookup, learn and tick walks all ENTRIES slots through the
//   entry store, one read per cycle; a learn then adds a write-back state.
//   Unused codes and learns with an out-of-range port skip the scan.
//   One request is worked at a time; the read port of the store sets rate.
//   The next beat is taken in the cycle after the result is handed on.
// Reset: control clears at once, then a clearing pass writes every slot
//   invalid, with in_ready low throughout. cfg writes are taken anyway.
// Stall: the result sits in an output register; the next request is taken
//   and scanned meanwhile, and waits at its end until out_ready frees it.
// ----------------------------------------------------------------------------
module mac_learning_table_aging_core #(
	parameter int ENTRIES = 64,
	parameter int PORTS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mlta_pkg::REQ_W-1:0]      req_type,
	input  logic [mlta_pkg::MAC_W-1:0]      mac_addr,
	input  logic [mlta_pkg::PORT_W-1:0]     port_in,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [mlta_pkg::PORT_W-1:0]     port_out,
	output logic                            learned_new,
	output logic                            table_full,
	output logic [mlta_pkg::CNT_W-1:0]      removed_count,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mlta_pkg::TMO_W-1:0]      age_timeout
);

	localparam int AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;  // post-reset clearing pass
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;  // issue reads 0..ENTRIES-1
	localparam logic [2:0] ST_DRAIN = 3'd3;  // judge last read
	localparam logic [2:0] ST_WRITE = 3'd4;  // learn write-back
	localparam logic [2:0] ST_FIN   = 3'd5;  // hand result to output reg

	logic [2:0]                        state_q;
	logic [AW-1:0]                     clr_addr_q;
	logic [AW-1:0]                     rd_addr_q;
	logic                              rd_vld_s1;
	logic [AW-1:0]                     rd_idx_s1;

	logic [mlta_pkg::REQ_W-1:0]        req_q;
	logic [mlta_pkg::MAC_W-1:0]        mac_q;
	logic [mlta_pkg::PORT_W-1:0]       port_q;
	logic [mlta_pkg::STAMP_W-1:0]      seconds_q;
	logic [mlta_pkg::TMO_W-1:0]        timeout_q;

	logic                              found_q;
	logic [AW-1:0]                     found_idx_q;
	logic [mlta_pkg::PORT_W-1:0]       hit_port_q;
	logic                              free_q;
	logic [AW-1:0]                     free_idx_q;
	logic [mlta_pkg::CNT_W-1:0]        removed_q;

	logic                              out_valid_q;
	logic                              hit_q;
	logic [mlta_pkg::PORT_W-1:0]       port_out_q;
	logic                              learned_q;
	logic                              full_q;
	logic [mlta_pkg::CNT_W-1:0]        removed_out_q;

	// store interface
	logic                              mem_we;
	logic [AW-1:0]                     mem_waddr;
	mlta_pkg::entry_t                  mem_wdata;
	logic                              mem_re;
	mlta_pkg::entry_t                  mem_rdata;
	mlta_pkg::eval_t                   ev;

	logic                              in_fire;
	logic                              port_ok;
	logic                              fin_go;
	logic                              is_tick;
	logic                              expire_wr;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign port_ok   = 32'(port_in) < 32'(PORTS);
	assign is_tick   = (req_q == mlta_pkg::REQ_TICK);
	// result may leave for the output register once it is empty or draining
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign expire_wr = is_tick && rd_vld_s1 && ev.expire &&
		((state_q == ST_SCAN) || (state_q == ST_DRAIN));

	mlta_mem #(
		.ENTRIES (ENTRIES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_addr_q),
		.rdata (mem_rdata)
	);

	mlta_eval u_eval (
		.entry   (mem_rdata),
		.mac     (mac_q),
		.now     (seconds_q),
		.timeout (timeout_q),
		.ev      (ev)
	);

	// Write port: clearing pass, aging invalidation, or learn write-back.
	// Aging writes slot i while slot i+1 is being read, so no overlap.
	always_comb begin
		mem_re    = (state_q == ST_SCAN);
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_SCAN, ST_DRAIN: begin
				mem_we          = expire_wr;
				mem_waddr       = rd_idx_s1;
				mem_wdata       = mem_rdata;
				mem_wdata.valid = 1'b0;
			end
			ST_WRITE: begin
				mem_we          = found_q || free_q;
				mem_waddr       = found_q ? found_idx_q : free_idx_q;
				mem_wdata.valid = 1'b1;
				mem_wdata.mac   = mac_q;
				mem_wdata.port  = port_q;
				mem_wdata.stamp = seconds_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			rd_addr_q  <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					rd_addr_q <= '0;
					if (in_fire) begin
						if (req_type == mlta_pkg::REQ_NONE ||
						    (req_type == mlta_pkg::REQ_LEARN && !port_ok)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_addr_q <= rd_addr_q + 1'b1;
					if (rd_addr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= (req_q == mlta_pkg::REQ_LEARN) ? ST_WRITE : ST_FIN;
				end
				ST_WRITE: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pipeline index of the read in flight
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q;
	end

	// request latch, seconds counter, timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q     <= mlta_pkg::REQ_NONE;
			seconds_q <= '0;
			timeout_q <= mlta_pkg::TMO_DEFAULT;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= age_timeout;
			end
			if (in_fire) begin
				// a learn with a bad port behaves as an unused code
				if (req_type == mlta_pkg::REQ_LEARN && !port_ok) begin
					req_q <= mlta_pkg::REQ_NONE;
				end else begin
					req_q <= req_type;
				end
				if (req_type == mlta_pkg::REQ_TICK) begin
					seconds_q <= seconds_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mac_q  <= mac_addr;
			port_q <= port_in;
		end
	end

	// scan bookkeeping: first match, first free slot, removal count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
		end else if (in_fire) begin
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
		end else if (rd_vld_s1) begin
			if (ev.hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (ev.free && !free_q) begin
				free_q <= 1'b1;
			end
			if (expire_wr && removed_q != mlta_pkg::CNT_MAX) begin
				removed_q <= removed_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && ev.hit && !found_q) begin
			found_idx_q <= rd_idx_s1;
			hit_port_q  <= mem_rdata.port;
		end
		if (rd_vld_s1 && ev.free && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			hit_q <= found_q &&
				(req_q == mlta_pkg::REQ_LOOKUP || req_q == mlta_pkg::REQ_LEARN);
			port_out_q    <= (found_q && req_q == mlta_pkg::REQ_LOOKUP) ? hit_port_q : '0;
			learned_q     <= (req_q == mlta_pkg::REQ_LEARN) && !found_q && free_q;
			full_q        <= (req_q == mlta_pkg::REQ_LEARN) && !found_q && !free_q;
			removed_out_q <= is_tick ? removed_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign port_out      = port_out_q;
	assign learned_new   = learned_q;
	assign table_full    = full_q;
	assign removed_count = removed_out_q;

endmodule

FILE: src/mlta_checker.sv
// ----------------------------------------------------------------------------
// mlta_checker
// Port-level checks of the MAC learning table, bound to the top level.
// ----------------------------------------------------------------------------
module mlta_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            hit,
	input logic [mlta_pkg::PORT_W-1:0]     port_out,
	input logic                            learned_new,
	input logic                            table_full,
	input logic [mlta_pkg::CNT_W-1:0]      removed_count
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) &&
		$stable(port_out) && $stable(learned_new) && $stable(table_full) &&
		$stable(removed_count))
		else $error("result beat changed while stalled");

	// one request at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a learn either matched, created, or was dropped
	a_learn_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(learned_new && table_full) && !(hit && learned_new) &&
		!(hit && table_full))
		else $error("conflicting learn flags");

	// removals come only from ticks
	a_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && removed_count != '0 |-> !hit && !learned_new && !table_full)
		else $error("removal reported on a non-tick beat");

	// a port is reported only with a hit
	a_port_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && port_out != '0 |-> hit)
		else $error("port reported without a hit");

endmodule

bind mac_learning_table_aging_core mlta_checker u_mlta_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.hit           (hit),
	.port_out      (port_out),
	.learned_new   (learned_new),
	.table_full    (table_full),
	.removed_count (removed_count)
);

FILE: tb/tb_mac_learning_table_aging_core.sv
// ----------------------------------------------------------------------------
// tb_mac_learning_table_aging_core
// Self-checking bench for the MAC learning table with aging. A queue-fed
// driver offers lookup, learn, tick and unused-code requests with random
// gaps. A clocked monitor checks every result beat against a table model.
// The timeout register is rewritten between phases, with the table idle.
// ----------------------------------------------------------------------------
module tb_mac_learning_table_aging_core;

	localparam int ENTRIES     = 64;
	localparam int PORTS       = 16;
	localparam int CLK_PERIOD  = 8;
	localparam int PHASE_ITEMS = 285;

	// request as offered on the input channel
	typedef struct packed {
		logic [mlta_pkg::REQ_W-1:0]  kind;
		logic [mlta_pkg::MAC_W-1:0]  mac;
		logic [mlta_pkg::PORT_W-1:0] port;
	} lt_req_t;

	// result fields as returned on the output channel
	typedef struct packed {
		logic                        hit;
		logic [mlta_pkg::PORT_W-1:0] port;
		logic                        learned;
		logic                        full;
		logic [mlta_pkg::CNT_W-1:0]  removed;
	} lt_rsp_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [mlta_pkg::REQ_W-1:0]    req_type = '0;
	logic [mlta_pkg::MAC_W-1:0]    mac_addr = '0;
	logic [mlta_pkg::PORT_W-1:0]   port_in = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          hit;
	logic [mlta_pkg::PORT_W-1:0]   port_out;
	logic                          learned_new;
	logic                          table_full;
	logic [mlta_pkg::CNT_W-1:0]    removed_count;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [mlta_pkg::TMO_W-1:0]    age_timeout = '0;

	// table model: mirrors the DUT store, updated at each accepted request
	logic                          tab_valid [ENTRIES];
	logic [mlta_pkg::MAC_W-1:0]    tab_mac   [ENTRIES];
	logic [mlta_pkg::PORT_W-1:0]   tab_port  [ENTRIES];
	logic [mlta_pkg::STAMP_W-1:0]  tab_stamp [ENTRIES];
	logic [mlta_pkg::STAMP_W-1:0]  sec_now = '0;
	logic [mlta_pkg::TMO_W-1:0]    tmo_cfg = mlta_pkg::TMO_DEFAULT;

	lt_req_t             pending_q [$];   // requests waiting for the driver
	lt_rsp_t             expect_q  [$];   // predicted results, oldest first
	lt_rsp_t             want;

	logic                in_fire = 1'b0;  // request beat taken at the last edge
	int unsigned         gap_left = 0;
	int unsigned         stall_left = 0;
	bit                  tx_steady = 1'b0;
	bit                  rx_steady = 1'b0;
	bit                  long_hold_done = 1'b0;
	int                  results_seen = 0;
	int                  err_cnt = 0;

	mac_learning_table_aging_core #(
		.ENTRIES(ENTRIES),
		.PORTS  (PORTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.mac_addr     (mac_addr),
		.port_in      (port_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.port_out     (port_out),
		.learned_new  (learned_new),
		.table_full   (table_full),
		.removed_count(removed_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.age_timeout  (age_timeout)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		foreach (tab_valid[i]) tab_valid[i] = 1'b0;
	end

	// ------------------------------------------------------------------
	// table model
	// ------------------------------------------------------------------

	// slot holding this MAC, -1 if none; only valid slots are compared
	function automatic int find_mac(input logic [mlta_pkg::MAC_W-1:0] mac);
		for (int i = 0; i < ENTRIES; i++)
			if (tab_valid[i] && tab_mac[i] == mac)
				return i;
		return -1;
	endfunction

	function automatic lt_rsp_t predict_table(input lt_req_t r);
		lt_rsp_t                      rsp;
		int                           slot;
		logic [mlta_pkg::STAMP_W-1:0] age;
		rsp = '0;
		case (r.kind)
			mlta_pkg::REQ_LOOKUP: begin
				// lookup leaves the stamp alone
				slot = find_mac(r.mac);
				if (slot >= 0) begin
					rsp.hit  = 1'b1;
					rsp.port = tab_port[slot];
				end
			end
			mlta_pkg::REQ_LEARN: begin
				if (int'(r.port) < PORTS) begin
					slot = find_mac(r.mac);
					if (slot >= 0) begin
						rsp.hit         = 1'b1;
						tab_port[slot]  = r.port;
						tab_stamp[slot] = sec_now;
					end else begin
						// new MAC goes to the lowest free slot
						for (int i = ENTRIES - 1; i >= 0; i--)
							if (!tab_valid[i])
								slot = i;
						if (slot >= 0) begin
							tab_valid[slot] = 1'b1;
							tab_mac[slot]   = r.mac;
							tab_port[slot]  = r.port;
							tab_stamp[slot] = sec_now;
							rsp.learned     = 1'b1;
						end else begin
							rsp.full = 1'b1;
						end
					end
				end
			end
			mlta_pkg::REQ_TICK: begin
				// advance first, then sweep with modular ages
				sec_now = sec_now + 1'b1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (tab_valid[i]) begin
						age = sec_now - tab_stamp[i];
						if (age > {1'b0, tmo_cfg}) begin
							tab_valid[i] = 1'b0;
							if (rsp.removed != mlta_pkg::CNT_MAX)
								rsp.removed = rsp.removed + 1'b1;
						end
					end
				end
			end
			default: begin
				// unused code: no state change, all fields zero
			end
		endcase
		return rsp;
	endfunction

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(input bit steady);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic [mlta_pkg::MAC_W-1:0] rand_mac();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[mlta_pkg::MAC_W-1:0];
	endfunction

	function automatic void add_item(input logic [mlta_pkg::REQ_W-1:0] kind,
			input logic [mlta_pkg::MAC_W-1:0] mac,
			input logic [mlta_pkg::PORT_W-1:0] port);
		pending_q.push_back('{kind: kind, mac: mac, port: port});
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_cnt < 40)
			$display("%0t: mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	// timeout write; only called with nothing in flight
	task automatic set_timeout(input logic [mlta_pkg::TMO_W-1:0] v);
		@(negedge clk);
		cfg_valid   <= 1'b1;
		age_timeout <= v;
		do @(posedge clk); while (!cfg_ready);
		tmo_cfg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sampled at posedge: driver updates land at negedge, so no race
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_q.size() != 0 || in_valid || expect_q.size() != 0);
	endtask

	// One random phase. Requests mostly hit a pool of MACs so learns refresh
	// and lookups hit; some are one-bit neighbors of pool MACs (near misses)
	// or fresh random MACs. A big pool with heavy learning fills the table.
	task automatic run_random_phase(input logic [mlta_pkg::TMO_W-1:0] tmo,
			input int pool_n, input int tick_pct, input int learn_pct,
			input bit tx_st, input bit rx_st);
		logic [mlta_pkg::MAC_W-1:0] pool [128];
		logic [mlta_pkg::MAC_W-1:0] mac;
		logic [mlta_pkg::REQ_W-1:0] kind;
		int unsigned                r;
		foreach (pool[i]) pool[i] = rand_mac();
		tx_steady = tx_st;
		rx_steady = rx_st;
		set_timeout(tmo);
		repeat (PHASE_ITEMS) begin
			r   = $urandom_range(0, 99);
			mac = pool[$urandom_range(0, pool_n - 1)];
			if ($urandom_range(0, 9) == 0)
				mac = mac ^ (48'd1 << $urandom_range(0, mlta_pkg::MAC_W - 1));
			else if ($urandom_range(0, 19) == 0)
				mac = rand_mac();
			if (r < tick_pct)
				kind = mlta_pkg::REQ_TICK;
			else if (r < tick_pct + 3)
				kind = mlta_pkg::REQ_NONE;
			else if (r < tick_pct + 3 + learn_pct)
				kind = mlta_pkg::REQ_LEARN;
			else
				kind = mlta_pkg::REQ_LOOKUP;
			add_item(kind, mac, mlta_pkg::PORT_W'($urandom_range(0, 15)));
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// request driver: changes at negedge, holds the beat until taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// beat still pending, hold payload
		end else if (gap_left != 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_q.size() != 0) begin
			req_type <= pending_q[0].kind;
			mac_addr <= pending_q[0].mac;
			port_in  <= pending_q[0].port;
			in_valid <= 1'b1;
			gap_left <= pick_gap(tx_steady);
			void'(pending_q.pop_front());
		end else begin
			in_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// result ready: random stalls, plus one long hold-off once traffic is
	// flowing so both the result register and the scan stage fill up and
	// the request channel backs up
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!long_hold_done && results_seen >= 400) begin
			long_hold_done <= 1'b1;
			stall_left     <= 2500;
			out_ready      <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready  <= 1'b1;
			stall_left <= pick_gap(rx_steady);
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on request beats, check result beats, in order
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expect_q.size() == 0) begin
					report_mismatch("result beat with no request outstanding");
				end else begin
					want = expect_q.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("beat %0d hit %b exp %b",
							results_seen, hit, want.hit));
					if (port_out !== want.port)
						report_mismatch($sformatf("beat %0d port_out %0d exp %0d",
							results_seen, port_out, want.port));
					if (learned_new !== want.learned)
						report_mismatch($sformatf("beat %0d learned_new %b exp %b",
							results_seen, learned_new, want.learned));
					if (table_full !== want.full)
						report_mismatch($sformatf("beat %0d table_full %b exp %b",
							results_seen, table_full, want.full));
					if (removed_count !== want.removed)
						report_mismatch($sformatf("beat %0d removed_count %0d exp %0d",
							results_seen, removed_count, want.removed));
				end
			end
			// predicted after the pop; a result never leaves on its own accept edge
			if (in_valid && in_ready)
				expect_q.push_back(predict_table('{kind: req_type, mac: mac_addr,
					port: port_in}));
		end
	end

	// ------------------------------------------------------------------
	// stimulus sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, refresh, near miss, unused code, aging
		set_timeout(15'd2);
		add_item(mlta_pkg::REQ_LOOKUP, 48'h0, 4'd0);               // miss on empty
		add_item(mlta_pkg::REQ_LEARN, 48'h0, 4'd0);                // new, slot 0
		add_item(mlta_pkg::REQ_LEARN, 48'hFFFF_FFFF_FFFF, 4'd15);  // new, slot 1
		add_item(mlta_pkg::REQ_LOOKUP, 48'h0, 4'd15);
		add_item(mlta_pkg::REQ_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'd0);
		add_item(mlta_pkg::REQ_LOOKUP, 48'hFFFF_FFFF_FFFE, 4'd0);  // one bit off
		add_item(mlta_pkg::REQ_LEARN, 48'h0, 4'd15);               // port moves
		add_item(mlta_pkg::REQ_LOOKUP, 48'h0, 4'd0);
		add_item(mlta_pkg::REQ_NONE, 48'hFFFF_FFFF_FFFF, 4'd15);   // unused code
		add_item(mlta_pkg::REQ_TICK, 48'hFFFF_FFFF_FFFF, 4'd15);
		add_item(mlta_pkg::REQ_TICK, 48'h0, 4'd0);
		add_item(mlta_pkg::REQ_TICK, 48'h0, 4'd0);                 // age 3 > 2
		add_item(mlta_pkg::REQ_LOOKUP, 48'h0, 4'd0);
		add_item(mlta_pkg::REQ_LEARN, 48'h8000_0000_0001, 4'd8);
		add_item(mlta_pkg::REQ_LEARN, 48'h1234_5678_9ABC, 4'd7);
		wait_drained();

		// zero timeout: anything with nonzero age goes on the next tick
		set_timeout(15'd0);
		add_item(mlta_pkg::REQ_TICK, 48'h0, 4'd0);
		add_item(mlta_pkg::REQ_LEARN, 48'h5A5A_5A5A_5A5A, 4'd5);
		add_item(mlta_pkg::REQ_LOOKUP, 48'h5A5A_5A5A_5A5A, 4'd0);
		add_item(mlta_pkg::REQ_TICK, 48'h0, 4'd0);
		add_item(mlta_pkg::REQ_LEARN, 48'hA5A5_A5A5_A5A5, 4'd10);
		wait_drained();

		// random phases; the max-timeout phase fills the table and the
		// zero-timeout phase after it sweeps a full table in one tick
		run_random_phase(15'd5, 24, 12, 40, 1'b0, 1'b0);
		run_random_phase(15'd32767, 90, 2, 75, 1'b1, 1'b0);
		run_random_phase(15'd0, 12, 25, 35, 1'b0, 1'b1);
		run_random_phase(15'd1, 40, 10, 45, 1'b0, 1'b0);
		run_random_phase(15'd3, 70, 6, 55, 1'b1, 1'b1);
		run_random_phase(mlta_pkg::TMO_W'($urandom_range(2, 40)), 50, 8, 45,
			1'b0, 1'b0);

		// let any stray beat show up before judging
		repeat (ENTRIES + 8) @(posedge clk);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

endmodule
